FILE: design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // TABLE_SLOTS is a power of two
  localparam int TABLE_SLOTS   = 1024;
  localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
  localparam int KEY_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  localparam int ENTRY_BITS    = KEY_BITS + VALUE_BITS;
  localparam int HASH_BITS     = 32;
  localparam int MOD_BITS      = 11;
  localparam int OCC_BITS      = 11;
  localparam int INDEX_BITS    = 10;
  localparam int STATUS_BITS   = 2;
  localparam int OP_BITS       = 2;
  localparam int MARK_BITS     = 2;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // remainder unit retires two dividend bits per step
  localparam int DIV_STEPS     = HASH_BITS / 2;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  // insert of an absent key is refused once 4*occupied >= 3*TABLE_SLOTS
  localparam int FULL_LEVEL    = (3 * TABLE_SLOTS + 3) / 4;

  localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(1021);

  // register index, taken from paddr[2]
  localparam logic REG_HASH_MODULUS = 1'b0;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [MARK_BITS-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_NEW  = 2'd0,
    ST_OK   = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CM_NONE   = 3'd0,
    CM_UPDATE = 3'd1,
    CM_NEW    = 3'd2,
    CM_TOMB   = 3'd3,
    CM_FOUND  = 3'd4,
    CM_MISS   = 3'd5,
    CM_FULL   = 3'd6
  } commit_t;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_DIVIDE = 3'd2,
    S_HOME   = 3'd3,
    S_READ   = 3'd4,
    S_CHECK  = 3'd5,
    S_FINAL  = 3'd6
  } state_t;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    probe_init;
    logic    probe_next;
    logic    take_free;
    logic    clear_step;
    commit_t commit;
  } cmd_t;

  typedef struct packed {
    logic                 clear_last;
    logic                 div_last;
    logic [OP_BITS-1:0]   op;
    logic [MARK_BITS-1:0] mark;
    logic                 key_match;
    logic                 probe_last;
    logic                 have_free;
    logic                 full;
  } stat_t;

endpackage

FILE: design/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// Sequence: hash remainder steps, a home slot step, then one slot memory read
//   plus one check per probe; an insert of a new key or a full refusal ends
//   with a separate final commit step.
// Throughput: one request at a time; the next start is taken in the done cycle.
// Reset: a sweep marks every slot empty, busy stays high meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_BITS-1:0]       operation,
  input  logic [KEY_BITS-1:0]      key,
  input  logic [HASH_BITS-1:0]     key_hash,
  input  logic [VALUE_BITS-1:0]    value,
  output logic                     done,
  output logic [STATUS_BITS-1:0]   status,
  output logic [VALUE_BITS-1:0]    found_value,
  output logic [INDEX_BITS-1:0]    slot_index,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cmd_t    cmd;
  stat_t   stat;
  status_t status_q;

  assign pready = 1'b1;
  assign status = STATUS_BITS'(status_q);

  lpht_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  lpht_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .operation  (operation),
    .key        (key),
    .key_hash   (key_hash),
    .value      (value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .done       (done),
    .status_q   (status_q),
    .found_value(found_value),
    .slot_index (slot_index)
  );

endmodule

FILE: design/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Request sequencer: table clear, hash reduction, probe walk and commit.
// ----------------------------------------------------------------------------
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;
  logic   op_known;
  logic   is_insert;
  logic   is_lookup;
  logic   hit;

  assign op_known  = (stat.op == OP_INSERT) || (stat.op == OP_LOOKUP) ||
                     (stat.op == OP_DELETE);
  assign is_insert = (stat.op == OP_INSERT);
  assign is_lookup = (stat.op == OP_LOOKUP);
  assign hit       = (stat.mark == MARK_USED) && stat.key_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_DIVIDE;
      S_DIVIDE: if (stat.div_last) state_next = S_HOME;
      S_HOME:   state_next = op_known ? S_READ : S_IDLE;
      S_READ:   state_next = S_CHECK;
      S_CHECK: begin
        if (is_insert) begin
          if (stat.mark == MARK_EMPTY) begin
            state_next = S_FINAL;
          end else if (hit) begin
            state_next = S_IDLE;
          end else begin
            state_next = stat.probe_last ? S_FINAL : S_READ;
          end
        end else begin
          if (stat.mark == MARK_EMPTY || hit || stat.probe_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_FINAL:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.commit = CM_NONE;
    busy       = (state != S_IDLE);
    unique case (state)
      S_CLEAR:  cmd.clear_step = 1'b1;
      S_IDLE:   cmd.load = start;
      S_DIVIDE: cmd.div_step = 1'b1;
      S_HOME: begin
        if (op_known) begin
          cmd.probe_init = 1'b1;
        end else begin
          cmd.commit = CM_MISS;
        end
      end
      S_READ: ;
      S_CHECK: begin
        if (is_insert) begin
          if (stat.mark == MARK_EMPTY) begin
            cmd.take_free = 1'b1;
          end else if (stat.mark == MARK_TOMB) begin
            cmd.take_free  = 1'b1;
            cmd.probe_next = !stat.probe_last;
          end else if (hit) begin
            cmd.commit = CM_UPDATE;
          end else begin
            cmd.probe_next = !stat.probe_last;
          end
        end else begin
          if (stat.mark == MARK_EMPTY) begin
            cmd.commit = CM_MISS;
          end else if (hit) begin
            cmd.commit = is_lookup ? CM_FOUND : CM_TOMB;
          end else if (stat.probe_last) begin
            cmd.commit = CM_MISS;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end
      end
      S_FINAL:  cmd.commit = (stat.full || !stat.have_free) ? CM_FULL : CM_NEW;
      default: ;
    endcase
  end

endmodule

FILE: design/lpht_datapath.sv
// ----------------------------------------------------------------------------
// lpht_datapath
// Request registers, hash remainder unit, probe pointer, slot memories,
// occupancy count, configuration register and result registers.
// ----------------------------------------------------------------------------
module lpht_datapath
  import lpht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [OP_BITS-1:0]       operation,
  input  logic [KEY_BITS-1:0]      key,
  input  logic [HASH_BITS-1:0]     key_hash,
  input  logic [VALUE_BITS-1:0]    value,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     done,
  output status_t                  status_q,
  output logic [VALUE_BITS-1:0]    found_value,
  output logic [INDEX_BITS-1:0]    slot_index
);

  logic [MOD_BITS-1:0]     hash_modulus;
  logic [OP_BITS-1:0]      op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [VALUE_BITS-1:0]   value_q;
  logic [HASH_BITS-1:0]    dividend;
  logic [MOD_BITS-1:0]     rem;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [SLOT_BITS-1:0]    slot;
  logic [SLOT_BITS-1:0]    probe_cnt;
  logic [SLOT_BITS-1:0]    free_slot;
  logic                    have_free;
  logic [SLOT_BITS-1:0]    clr_addr;
  logic [OCC_BITS-1:0]     occupied_count;

  logic [MOD_BITS:0]       r_a, r_b;
  logic [MOD_BITS-1:0]     rem_a, rem_next;
  logic [SLOT_BITS-1:0]    home_slot;
  logic [SLOT_BITS-1:0]    slot_next;

  logic                    mark_we;
  logic [SLOT_BITS-1:0]    mark_waddr;
  logic [MARK_BITS-1:0]    mark_wdata;
  logic [MARK_BITS-1:0]    mark_rdata;
  logic                    entry_we;
  logic [SLOT_BITS-1:0]    entry_waddr;
  logic [ENTRY_BITS-1:0]   entry_rdata;

  // APB configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_modulus <= MOD_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HASH_MODULUS)) begin
      hash_modulus <= pwdata[MOD_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_HASH_MODULUS) ? APB_DATA_BITS'(hash_modulus) : '0;

  // remainder of key_hash by hash_modulus, two bits per step
  always_comb begin
    r_a      = {rem, dividend[HASH_BITS-1]};
    rem_a    = (r_a >= {1'b0, hash_modulus}) ? MOD_BITS'(r_a - {1'b0, hash_modulus})
                                             : r_a[MOD_BITS-1:0];
    r_b      = {rem_a, dividend[HASH_BITS-2]};
    rem_next = (r_b >= {1'b0, hash_modulus}) ? MOD_BITS'(r_b - {1'b0, hash_modulus})
                                             : r_b[MOD_BITS-1:0];
  end

  assign home_slot = (hash_modulus == '0) ? '0 : SLOT_BITS'(rem);
  assign slot_next = (slot == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : slot + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= operation;
      key_q    <= key;
      value_q  <= value;
      dividend <= key_hash;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[HASH_BITS-3:0], 2'b00};
      rem      <= rem_next;
      div_cnt  <= div_cnt + 1'b1;
    end
  end

  // probe pointer and first reusable slot
  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      slot      <= home_slot;
      probe_cnt <= '0;
      have_free <= 1'b0;
    end else begin
      if (cmd.probe_next) begin
        slot      <= slot_next;
        probe_cnt <= probe_cnt + 1'b1;
      end
      if (cmd.take_free && !have_free) begin
        have_free <= 1'b1;
        free_slot <= slot;
      end
    end
  end

  // clear sweep and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      occupied_count <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit == CM_NEW) begin
        occupied_count <= occupied_count + 1'b1;
      end else if (cmd.commit == CM_TOMB && occupied_count != '0) begin
        occupied_count <= occupied_count - 1'b1;
      end
    end
  end

  // slot memories
  always_comb begin
    mark_we     = cmd.clear_step || (cmd.commit == CM_NEW) || (cmd.commit == CM_TOMB);
    mark_waddr  = slot;
    mark_wdata  = MARK_TOMB;
    if (cmd.clear_step) begin
      mark_waddr = clr_addr;
      mark_wdata = MARK_EMPTY;
    end else if (cmd.commit == CM_NEW) begin
      mark_waddr = free_slot;
      mark_wdata = MARK_USED;
    end
    entry_we    = (cmd.commit == CM_NEW) || (cmd.commit == CM_UPDATE);
    entry_waddr = (cmd.commit == CM_NEW) ? free_slot : slot;
  end

  lpht_ram #(
    .WIDTH(MARK_BITS),
    .DEPTH(TABLE_SLOTS)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .raddr(slot),
    .rdata(mark_rdata)
  );

  lpht_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(TABLE_SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (entry_we),
    .waddr(entry_waddr),
    .wdata({key_q, value_q}),
    .raddr(slot),
    .rdata(entry_rdata)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.commit != CM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.commit)
      CM_UPDATE, CM_TOMB: begin
        status_q    <= ST_OK;
        found_value <= '0;
        slot_index  <= INDEX_BITS'(slot);
      end
      CM_FOUND: begin
        status_q    <= ST_OK;
        found_value <= entry_rdata[VALUE_BITS-1:0];
        slot_index  <= INDEX_BITS'(slot);
      end
      CM_NEW: begin
        status_q    <= ST_NEW;
        found_value <= '0;
        slot_index  <= INDEX_BITS'(free_slot);
      end
      CM_MISS: begin
        status_q    <= ST_MISS;
        found_value <= '0;
        slot_index  <= '0;
      end
      CM_FULL: begin
        status_q    <= ST_FULL;
        found_value <= '0;
        slot_index  <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.clear_last = (clr_addr == SLOT_BITS'(TABLE_SLOTS - 1));
    stat.div_last   = (div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1));
    stat.op         = op_q;
    stat.mark       = mark_rdata;
    stat.key_match  = (entry_rdata[ENTRY_BITS-1 -: KEY_BITS] == key_q);
    stat.probe_last = (probe_cnt == SLOT_BITS'(TABLE_SLOTS - 1));
    stat.have_free  = have_free;
    stat.full       = (occupied_count >= OCC_BITS'(FULL_LEVEL));
  end

endmodule

FILE: design/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the request/result transfer sequence.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [STATUS_BITS-1:0] status,
  input logic [VALUE_BITS-1:0]  found_value,
  input logic [INDEX_BITS-1:0]  slot_index
);

  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("no clear sweep after reset");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transfer did not start work");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_BITS'(ST_MISS) || done && status == STATUS_BITS'(ST_FULL)))
    |-> (found_value == '0 && slot_index == '0))
    else $error("nonzero fields on miss or full");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

FILE: test/linear_probe_hash_table_test.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Self-checking bench for the linear probing key/value table. Requests go in
// through the start/busy handshake, the modulus register through APB. A
// tracker keeps its own copy of slot marks, keys, values and occupancy,
// predicts the response of every accepted request and checks each done
// strobe in order. The run covers directed corner cases, random mixes under
// several modulus settings, and a clustered pass whose keys all share one
// home slot near the top of the table, so probe walks grow long, wrap past
// slot zero and cross tombstones.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNKNOWN = 2'd3;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_HASH_MODULUS =
    APB_ADDR_BITS'(4 * REG_HASH_MODULUS);

  typedef struct {
    status_t                status;
    logic [VALUE_BITS-1:0]  found_value;
    logic [INDEX_BITS-1:0]  slot_index;
  } response_t;

  class probe_table_tracker;
    mark_t                 slot_state [TABLE_SLOTS];
    logic [KEY_BITS-1:0]   slot_key   [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] slot_val   [TABLE_SLOTS];
    int                    occupancy;
    logic [MOD_BITS-1:0]   modulus;
    response_t             pending [$];
    int                    errors;
    int                    results;
    int                    status_count [4];
    int                    longest_walk;

    function new();
      foreach (slot_state[i]) slot_state[i] = MARK_EMPTY;
      occupancy = 0;
      modulus = MOD_RESET;
      errors = 0;
      results = 0;
      longest_walk = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function logic [SLOT_BITS-1:0] home_slot(logic [HASH_BITS-1:0] h);
      logic [HASH_BITS-1:0] r;
      r = (modulus == '0) ? '0 : h % HASH_BITS'(modulus);
      return r[SLOT_BITS-1:0];
    endfunction

    // one walk serves all operations: stop at an empty slot or a live match,
    // remember the first reusable slot on the way
    function void predict_response(logic [OP_BITS-1:0] op, logic [KEY_BITS-1:0] k,
                                   logic [HASH_BITS-1:0] h, logic [VALUE_BITS-1:0] v);
      response_t             r;
      logic [SLOT_BITS-1:0]  s;
      logic [SLOT_BITS-1:0]  free_slot;
      bit                    have_free;
      bit                    hit;
      int                    walk;
      r.status = ST_MISS;
      r.found_value = '0;
      r.slot_index = '0;
      s = home_slot(h);
      free_slot = '0;
      have_free = 0;
      hit = 0;
      for (walk = 0; walk < TABLE_SLOTS; walk++) begin
        if (slot_state[s] == MARK_EMPTY) begin
          if (!have_free) begin
            have_free = 1;
            free_slot = s;
          end
          break;
        end
        if (slot_state[s] == MARK_TOMB) begin
          if (!have_free) begin
            have_free = 1;
            free_slot = s;
          end
        end else if (slot_key[s] == k) begin
          hit = 1;
          break;
        end
        s = s + 1'b1;
      end
      if (walk < TABLE_SLOTS) walk++;
      if (walk > longest_walk) longest_walk = walk;
      case (op)
        OP_INSERT: begin
          if (hit) begin
            slot_val[s] = v;
            r.status = ST_OK;
            r.slot_index = s;
          end else if (4 * occupancy >= 3 * TABLE_SLOTS || !have_free) begin
            r.status = ST_FULL;
          end else begin
            slot_state[free_slot] = MARK_USED;
            slot_key[free_slot] = k;
            slot_val[free_slot] = v;
            occupancy++;
            r.status = ST_NEW;
            r.slot_index = free_slot;
          end
        end
        OP_LOOKUP: begin
          if (hit) begin
            r.status = ST_OK;
            r.found_value = slot_val[s];
            r.slot_index = s;
          end
        end
        OP_DELETE: begin
          if (hit) begin
            slot_state[s] = MARK_TOMB;
            if (occupancy > 0) occupancy--;
            r.status = ST_OK;
            r.slot_index = s;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_response(logic [STATUS_BITS-1:0] st, logic [VALUE_BITS-1:0] fv,
                        logic [INDEX_BITS-1:0] idx);
      response_t e;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("response with none pending: status %0d slot %0d", st, idx));
      end else begin
        e = pending.pop_front();
        status_count[e.status]++;
        if (st !== e.status || fv !== e.found_value || idx !== e.slot_index)
          report($sformatf("status %0d/%0d value %h/%h slot %0d/%0d (got/want)",
                           st, e.status, fv, e.found_value, idx, e.slot_index));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [OP_BITS-1:0]       operation;
  logic [KEY_BITS-1:0]      key;
  logic [HASH_BITS-1:0]     key_hash;
  logic [VALUE_BITS-1:0]    value;
  logic                     done;
  logic [STATUS_BITS-1:0]   status;
  logic [VALUE_BITS-1:0]    found_value;
  logic [INDEX_BITS-1:0]    slot_index;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  probe_table_tracker tracker = new();
  bit gaps_on;
  int calm_left;
  int requests_sent;
  int modulus_settings;

  linear_probe_hash_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .key         (key),
    .key_hash    (key_hash),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .slot_index  (slot_index),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(150ms);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_response(status, found_value, slot_index);
  end

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic issue(input logic [OP_BITS-1:0] op, input logic [KEY_BITS-1:0] k,
                       input logic [HASH_BITS-1:0] h, input logic [VALUE_BITS-1:0] v);
    if (gaps_on) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 24);
      else if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 8));
    end
    @(negedge clk);
    start = 1'b1;
    operation = op;
    key = k;
    key_hash = h;
    value = v;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.predict_response(op, k, h, v);
    requests_sent++;
  endtask

  task automatic drain_responses();
    @(negedge clk);
    start = 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = ADDR_HASH_MODULUS;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic write_modulus(input logic [MOD_BITS-1:0] m);
    logic [APB_DATA_BITS-1:0] rd;
    drain_responses();
    while (busy !== 1'b0) @(posedge clk);
    // upper bits are junk, the register keeps only its own width
    apb_transfer(1'b1, ($urandom() & ~32'h7FF) | APB_DATA_BITS'(m), rd);
    tracker.modulus = m;
    apb_transfer(1'b0, '0, rd);
    if (rd[MOD_BITS-1:0] !== m)
      tracker.report($sformatf("modulus readback %0d, wrote %0d", rd[MOD_BITS-1:0], m));
    modulus_settings++;
  endtask

  // hash whose home is slot s when the modulus equals the table size
  function automatic logic [HASH_BITS-1:0] hash_for_slot(int s);
    logic [HASH_BITS-1:0] h;
    h = $urandom();
    h[SLOT_BITS-1:0] = s[SLOT_BITS-1:0];
    return h;
  endfunction

  task automatic run_mixed_phase(input int count, input bit pause_midway);
    logic [KEY_BITS-1:0]  pool_key  [12];
    logic [HASH_BITS-1:0] pool_hash [12];
    logic [OP_BITS-1:0]   op;
    int                   p;
    int                   w;
    foreach (pool_key[i]) begin
      pool_key[i] = $urandom();
      pool_hash[i] = $urandom();
    end
    pool_key[0] = '0;
    pool_key[1] = '1;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain_responses();
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, 11);
        w = $urandom_range(0, 99);
        if (w < 45) op = OP_INSERT;
        else if (w < 75) op = OP_LOOKUP;
        else if (w < 95) op = OP_DELETE;
        else op = OP_UNKNOWN;
        issue(op, pool_key[p], pool_hash[p], $urandom());
      end else begin
        issue(OP_BITS'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  task automatic run_dense_phase();
    logic [KEY_BITS-1:0] live [$];
    logic [KEY_BITS-1:0] k;
    int                  j;
    write_modulus(11'd1024);
    gaps_on = 0;
    // one long run of keys homed near the top slot, wrapping past slot zero
    repeat (120) begin
      k = $urandom();
      live.push_back(k);
      issue(OP_INSERT, k, hash_for_slot(TABLE_SLOTS - 8), $urandom());
    end
    repeat (40) begin
      j = $urandom_range(0, live.size() - 1);
      issue(OP_LOOKUP, live[j], hash_for_slot(TABLE_SLOTS - 8), '0);
    end
    // deletes leave tombstones inside the run
    repeat (40) begin
      j = $urandom_range(0, live.size() - 1);
      issue(OP_DELETE, live[j], hash_for_slot(TABLE_SLOTS - 8), '0);
      live.delete(j);
    end
    // present keys past a tombstone update in place, absent keys reuse one
    repeat (30) begin
      j = $urandom_range(0, live.size() - 1);
      issue(OP_INSERT, live[j], hash_for_slot(TABLE_SLOTS - 8), $urandom());
    end
    repeat (20) issue(OP_INSERT, $urandom(), hash_for_slot(TABLE_SLOTS - 8), $urandom());
    repeat (20) issue(OP_LOOKUP, $urandom(), hash_for_slot(TABLE_SLOTS - 8), '0);
    issue(OP_UNKNOWN, $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    logic [APB_DATA_BITS-1:0] rd;
    logic [MOD_BITS-1:0]      mod_list [8];
    rst = 1'b1;
    start = 1'b0;
    operation = OP_INSERT;
    key = '0;
    key_hash = '0;
    value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1;
    calm_left = 0;
    requests_sent = 0;
    modulus_settings = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apb_transfer(1'b0, '0, rd);
    if (rd[MOD_BITS-1:0] !== MOD_RESET)
      tracker.report($sformatf("modulus after reset %0d", rd[MOD_BITS-1:0]));

    // directed: empty table, extremes, collisions, tombstones
    issue(OP_LOOKUP, '0, '0, '0);
    issue(OP_DELETE, '0, '0, '0);
    issue(OP_UNKNOWN, '1, '1, '1);
    issue(OP_INSERT, '0, '0, '0);
    issue(OP_INSERT, '1, '1, '1);
    issue(OP_LOOKUP, '1, '1, '0);
    issue(OP_INSERT, '0, '0, 32'hA5A5_A5A5);
    issue(OP_INSERT, 32'd1, 32'd1021, 32'h1111_1111);
    issue(OP_INSERT, 32'd2, 32'd0, 32'h2222_2222);
    issue(OP_DELETE, '0, '0, '1);
    issue(OP_LOOKUP, 32'd1, 32'd0, '0);
    issue(OP_INSERT, 32'd2, 32'd0, 32'h2BAD_2BAD);
    issue(OP_INSERT, 32'd3, 32'd2042, 32'h3333_3333);
    issue(OP_LOOKUP, '0, '0, '0);
    issue(OP_UNKNOWN, 32'd3, 32'd0, $urandom());
    write_modulus(11'd0);
    issue(OP_INSERT, 32'd10, $urandom(), $urandom());
    issue(OP_LOOKUP, 32'd10, $urandom(), $urandom());
    write_modulus(11'd2047);
    issue(OP_INSERT, 32'd11, 32'd2046, $urandom());
    issue(OP_INSERT, 32'd12, 32'd2047 * 5 + 32'd2000, $urandom());
    write_modulus(11'd1);
    issue(OP_INSERT, 32'd13, '1, $urandom());
    write_modulus(11'd1024);
    issue(OP_INSERT, 32'd14, 32'd1023, $urandom());
    issue(OP_INSERT, 32'd15, 32'd2047, $urandom());
    issue(OP_LOOKUP, 32'd15, '1, '0);

    mod_list[0] = 11'd2;
    mod_list[1] = 11'd1021;
    mod_list[2] = 11'd1;
    mod_list[3] = 11'd7;
    mod_list[4] = 11'd1024;
    mod_list[5] = 11'd0;
    mod_list[6] = 11'd2047;
    mod_list[7] = MOD_BITS'($urandom_range(2, 1024));
    foreach (mod_list[i]) begin
      write_modulus(mod_list[i]);
      run_mixed_phase(40, i == 3);
    end

    run_dense_phase();

    drain_responses();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests under %0d modulus settings:", requests_sent,
             modulus_settings);
    $display("  %0d new, %0d hit, %0d miss, %0d full; longest walk %0d slots, %0d live",
             tracker.status_count[ST_NEW], tracker.status_count[ST_OK],
             tracker.status_count[ST_MISS], tracker.status_count[ST_FULL],
             tracker.longest_walk, tracker.occupancy);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: linear_probe_hash_table.f
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_ctrl.sv
design/lpht_datapath.sv
design/linear_probe_hash_table.sv
design/lpht_checker.sv
test/linear_probe_hash_table_test.sv
